FILE: sv/wpg_pkg.sv
// Weather pixel generator package: constants, config/control structs and small
// arithmetic helpers shared by the config block, the divider and the top level.
// No dependencies.
package wpg_pkg;

	localparam int IMAGE_WIDTH  = 1024;
	localparam int IMAGE_HEIGHT = 1024;

	// register reset values
	localparam int RADIUS_RESET   = 160;
	localparam int ALTITUDE_RESET = 180;

	// triangle bands and speckle
	localparam int FRONT_PERIOD  = 240;
	localparam int FRONT_PEAK    = 120;
	localparam int STRIPE_PERIOD = 180;
	localparam int STRIPE_PEAK   = 90;
	localparam int TURB_PERIOD   = 150;
	localparam int TURB_PEAK     = 75;
	localparam int SPECKLE_MOD   = 97;
	localparam int SPECKLE_MIN   = 205;
	localparam int SPECKLE_RED   = 250;
	localparam int SPECKLE_GREEN = 245;
	localparam int SPECKLE_BLUE  = 220;

	// base gradients
	localparam int BLUE_BASE   = 85;
	localparam int BLUE_SLOPE  = 70;
	localparam int GREEN_BASE  = 55;
	localparam int GREEN_SLOPE = 65;
	localparam int RED_BASE    = 20;
	localparam int RED_SLOPE   = 30;

	// phase reduction: q = (p * recip) >> 20 is exact for p < 4096
	localparam int RECIP_SHIFT = 20;
	localparam logic [13:0] FRONT_RECIP   = 14'((2**RECIP_SHIFT + FRONT_PERIOD - 1) / FRONT_PERIOD);
	localparam logic [13:0] STRIPE_RECIP  =
		14'((2**RECIP_SHIFT + STRIPE_PERIOD - 1) / STRIPE_PERIOD);
	localparam logic [13:0] TURB_RECIP    = 14'((2**RECIP_SHIFT + TURB_PERIOD - 1) / TURB_PERIOD);
	localparam logic [13:0] SPECKLE_RECIP = 14'((2**RECIP_SHIFT + SPECKLE_MOD - 1) / SPECKLE_MOD);

	// small divides of byte values: (v * recip) >> 12
	localparam int DIV_SHIFT = 12;
	localparam logic [10:0] RECIP3 = 11'((2**DIV_SHIFT + 2) / 3);
	localparam logic [10:0] RECIP5 = 11'((2**DIV_SHIFT + 4) / 5);
	localparam logic [10:0] RECIP7 = 11'((2**DIV_SHIFT + 6) / 7);

	// falloff = radius^2 / 255, exact for 20-bit squares
	localparam int FALLOFF_DIV   = 255;
	localparam int FALLOFF_SHIFT = 28;
	localparam int FALLOFF_W     = 13;
	localparam logic [20:0] FALLOFF_RECIP =
		21'((2**FALLOFF_SHIFT + FALLOFF_DIV - 1) / FALLOFF_DIV);

	// signed seed residue mod 97 from byte weights 2^(8i) mod 97
	localparam int SEED_SHIFT = 24;
	localparam logic [17:0] SEED_RECIP = 18'((2**SEED_SHIFT + SPECKLE_MOD - 1) / SPECKLE_MOD);
	localparam int SEED_W1    = 256 % SPECKLE_MOD;
	localparam int SEED_W2    = (SEED_W1 * 256) % SPECKLE_MOD;
	localparam int SEED_W3    = (SEED_W2 * 256) % SPECKLE_MOD;
	localparam int SEED_WSIGN = (SPECKLE_MOD - (SEED_W3 * 256) % SPECKLE_MOD) % SPECKLE_MOD;

	typedef enum logic [2:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_RADIUS,
		REG_FRONT,
		REG_ALTITUDE,
		REG_SEED
	} cfg_reg_t;

	typedef struct packed {
		logic [9:0]           cx;
		logic [9:0]           cy;
		logic [7:0]           fo;
		logic [9:0]           ab;
		logic [31:0]          seed;
		logic [FALLOFF_W-1:0] falloff;
		logic [6:0]           seed_mod;
		logic                 busy;
	} wpg_cfg_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} div_en_t;

	function automatic logic [5:0] recip_quot(input logic [11:0] p, input logic [13:0] m);
		logic [25:0] prod;
		prod = 26'(p) * 26'(m);
		return prod[RECIP_SHIFT +: 6];
	endfunction

	function automatic logic [7:0] const_rem(input logic [11:0] p, input logic [5:0] q,
		input logic [7:0] c);
		logic [13:0] qc;
		logic [11:0] r;
		qc = 14'(q) * 14'(c);
		r = p - qc[11:0];
		return r[7:0];
	endfunction

	function automatic logic [6:0] tri_wave(input logic [7:0] rem, input logic [6:0] peak);
		logic [7:0] d;
		d = (rem >= {1'b0, peak}) ? rem - {1'b0, peak} : {1'b0, peak} - rem;
		return peak - d[6:0];
	endfunction

	function automatic logic [7:0] small_div(input logic [7:0] v, input logic [10:0] m);
		logic [18:0] prod;
		prod = 19'(v) * 19'(m);
		return {1'b0, prod[DIV_SHIFT +: 7]};
	endfunction

	function automatic logic [7:0] sat8(input logic [9:0] v);
		return (v > 10'd255) ? 8'hFF : v[7:0];
	endfunction

endpackage

FILE: sv/procedural_weather_pixel_generator.sv
// Weather map pixel generator top level: six-stage pixel pipeline.
// Throughput 1 pixel/cycle while neither out_ready back-pressure nor cfg.busy holds requests off.
// The divider (three stages of restoring steps) and the output register set the depth.
// Reset (arst_n low, async) clears pipeline valids and loads register defaults;
// pixel requests are held off after reset and after any config write while derived values settle.
// Depends on wpg_pkg, wpg_cfg, wpg_div.
module procedural_weather_pixel_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  pixel_x,
	input  logic [9:0]  pixel_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  blue,
	output logic [7:0]  green,
	output logic [7:0]  red
);
	import wpg_pkg::*;

	wpg_cfg_t cfg;
	div_en_t  div_en;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;
	logic accept;

	// stage 1
	logic [9:0]         x_s1, y_s1;
	logic signed [10:0] dx_s1, dy_s1;
	logic [11:0]        front_p_s1, stripe_p_s1, turb_p_s1, spk_p_s1;
	// stage 2
	logic [20:0] dist2_s2;
	logic [11:0] front_p_s2, stripe_p_s2, turb_p_s2, spk_p_s2;
	logic [5:0]  qf_s2, qst_s2, qt_s2, qs_s2;
	logic [8:0]  bbase_s2, gbase_s2, rbase_s2;
	// stage 3
	logic [6:0]  front_s3, stripe_s3, turb_s3;
	logic        spk_s3;
	logic [8:0]  bbase_s3, gbase_s3, rbase_s3;
	// stage 4, 5
	logic [9:0]  bsum_s4, gsum_s4, rsum_s4, bsum_s5, gsum_s5, rsum_s5;
	logic        spk_s4, spk_s5;
	// stage 6
	logic [7:0]  blue_s6, green_s6, red_s6;

	logic signed [10:0] dx_c, dy_c;
	logic signed [21:0] sqx_c, sqy_c;
	logic [16:0]        bx_c, gy_c, rxy_c;
	logic [7:0]         intensity;
	logic [9:0]         blue_c, green_c, red_c;
	logic               flash_c;

	wpg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// per-stage advance: a stage loads when empty or when the next one moves
	assign adv_s6   = !valid_s6 || out_ready;
	assign adv_s5   = !valid_s5 || adv_s6;
	assign adv_s4   = !valid_s4 || adv_s5;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1 && !cfg.busy;
	assign accept   = in_valid && in_ready;

	assign div_en = '{s3: adv_s3, s4: adv_s4, s5: adv_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= accept;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
			if (adv_s6) valid_s6 <= valid_s5;
		end
	end

	always_comb begin
		dx_c  = $signed({1'b0, pixel_x}) - $signed({1'b0, cfg.cx});
		dy_c  = $signed({1'b0, pixel_y}) - $signed({1'b0, cfg.cy});
		sqx_c = 22'(dx_s1) * 22'(dx_s1);
		sqy_c = 22'(dy_s1) * 22'(dy_s1);
		bx_c  = (17'(x_s1) * 17'(BLUE_SLOPE)) / 17'(IMAGE_WIDTH);
		gy_c  = (17'(y_s1) * 17'(GREEN_SLOPE)) / 17'(IMAGE_HEIGHT);
		rxy_c = ((17'(x_s1) + 17'(y_s1)) * 17'(RED_SLOPE)) / 17'(IMAGE_WIDTH + IMAGE_HEIGHT);
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			x_s1        <= pixel_x;
			y_s1        <= pixel_y;
			dx_s1       <= dx_c;
			dy_s1       <= dy_c;
			front_p_s1  <= 12'(pixel_x) + 12'(pixel_y) + 12'(cfg.fo);
			stripe_p_s1 <= {1'b0, pixel_y, 1'b0} + 12'(cfg.ab);
			turb_p_s1   <= 12'(pixel_x ^ pixel_y) + 12'(cfg.seed[7:0]);
			spk_p_s1    <= 12'(pixel_x) + 12'(pixel_y) + 12'(cfg.seed_mod);
		end
		if (adv_s2) begin
			dist2_s2    <= sqx_c[20:0] + sqy_c[20:0];
			front_p_s2  <= front_p_s1;
			stripe_p_s2 <= stripe_p_s1;
			turb_p_s2   <= turb_p_s1;
			spk_p_s2    <= spk_p_s1;
			qf_s2       <= recip_quot(front_p_s1, FRONT_RECIP);
			qst_s2      <= recip_quot(stripe_p_s1, STRIPE_RECIP);
			qt_s2       <= recip_quot(turb_p_s1, TURB_RECIP);
			qs_s2       <= recip_quot(spk_p_s1, SPECKLE_RECIP);
			bbase_s2    <= 9'(BLUE_BASE) + bx_c[8:0] + 9'(cfg.seed[20:16]);
			gbase_s2    <= 9'(GREEN_BASE) + gy_c[8:0] + 9'(cfg.seed[12:8]);
			rbase_s2    <= 9'(RED_BASE) + rxy_c[8:0] + 9'(cfg.seed[4:0]);
		end
		if (adv_s3) begin
			front_s3  <= tri_wave(const_rem(front_p_s2, qf_s2, 8'(FRONT_PERIOD)),
				7'(FRONT_PEAK));
			stripe_s3 <= tri_wave(const_rem(stripe_p_s2, qst_s2, 8'(STRIPE_PERIOD)),
				7'(STRIPE_PEAK));
			turb_s3   <= tri_wave(const_rem(turb_p_s2, qt_s2, 8'(TURB_PERIOD)),
				7'(TURB_PEAK));
			spk_s3    <= const_rem(spk_p_s2, qs_s2, 8'(SPECKLE_MOD)) == 8'd0;
			bbase_s3  <= bbase_s2;
			gbase_s3  <= gbase_s2;
			rbase_s3  <= rbase_s2;
		end
		if (adv_s4) begin
			bsum_s4 <= 10'(bbase_s3) + 10'(small_div({1'b0, front_s3}, RECIP5));
			gsum_s4 <= 10'(gbase_s3) + 10'(small_div({1'b0, stripe_s3}, RECIP3));
			rsum_s4 <= 10'(rbase_s3) + 10'(small_div({1'b0, front_s3}, RECIP3))
				+ 10'(turb_s3 >> 2);
			spk_s4  <= spk_s3;
		end
		if (adv_s5) begin
			bsum_s5 <= bsum_s4;
			gsum_s5 <= gsum_s4;
			rsum_s5 <= rsum_s4;
			spk_s5  <= spk_s4;
		end
		if (adv_s6) begin
			blue_s6  <= flash_c ? 8'(SPECKLE_BLUE) : sat8(blue_c);
			green_s6 <= flash_c ? 8'(SPECKLE_GREEN) : sat8(green_c);
			red_s6   <= flash_c ? 8'(SPECKLE_RED) : sat8(red_c);
		end
	end

	wpg_div u_div (
		.clk       (clk),
		.en        (div_en),
		.dist2     (dist2_s2),
		.falloff   (cfg.falloff),
		.intensity (intensity)
	);

	always_comb begin
		blue_c  = bsum_s5 + 10'(intensity >> 1);
		green_c = gsum_s5 + 10'(intensity >> 2);
		red_c   = rsum_s5 + 10'(small_div(intensity, RECIP7));
		flash_c = spk_s5 && (intensity > 8'(SPECKLE_MIN));
	end

	assign out_valid = valid_s6;
	assign blue      = blue_s6;
	assign green     = green_s6;
	assign red       = red_s6;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted pixel request lost at pipeline entry");

	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && adv_s6 |=> valid_s6)
		else $error("result lost between last stage and output register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !adv_s3 |=> valid_s3)
		else $error("stalled divider stage dropped its item");

endmodule

FILE: sv/wpg_cfg.sv
// Weather pixel generator configuration registers and derived values
// (falloff divisor, seed residue mod 97). Depends on wpg_pkg.
module wpg_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output wpg_pkg::wpg_cfg_t cfg
);
	import wpg_pkg::*;

	logic [9:0]  cx_q, cy_q, radius_q, ab_q;
	logic [7:0]  fo_q;
	logic [31:0] seed_q;
	logic [1:0]  busy_q;

	logic [19:0]          sq_q;
	logic [16:0]          wsum_q, wsum2_q;
	logic [FALLOFF_W-1:0] falloff_q;
	logic [9:0]           seedq_q;
	logic [6:0]           seed_mod_q;

	logic [16:0]          wsum_c;
	logic [40:0]          fprod;
	logic [FALLOFF_W-1:0] fq;
	logic [34:0]          sprod;
	logic [16:0]          smod_c;
	logic                 wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			radius_q <= 10'(RADIUS_RESET);
			fo_q     <= '0;
			ab_q     <= 10'(ALTITUDE_RESET);
			seed_q   <= '0;
			busy_q   <= 2'd3;
		end else begin
			if (wr) begin
				case (cfg_reg_t'(cfg_index))
					REG_CENTER_X: cx_q <= cfg_data[9:0];
					REG_CENTER_Y: cy_q <= cfg_data[9:0];
					REG_RADIUS:   radius_q <= cfg_data[9:0];
					REG_FRONT:    fo_q <= cfg_data[7:0];
					REG_ALTITUDE: ab_q <= cfg_data[9:0];
					REG_SEED:     seed_q <= cfg_data;
					default: ;
				endcase
			end
			// busy counts down after a write while the derived values settle
			if (wr) begin
				busy_q <= 2'd3;
			end else if (busy_q != 2'd0) begin
				busy_q <= busy_q - 2'd1;
			end
		end
	end

	always_comb begin
		wsum_c = 17'(seed_q[7:0])
			+ 17'(seed_q[15:8]) * 17'(SEED_W1)
			+ 17'(seed_q[23:16]) * 17'(SEED_W2)
			+ 17'(seed_q[31:24]) * 17'(SEED_W3)
			+ (seed_q[31] ? 17'(SEED_WSIGN) : 17'd0);
		fprod  = 41'(sq_q) * 41'(FALLOFF_RECIP);
		fq     = fprod[FALLOFF_SHIFT +: FALLOFF_W];
		sprod  = 35'(wsum_q) * 35'(SEED_RECIP);
		smod_c = wsum2_q - 17'(seedq_q) * 17'(SPECKLE_MOD);
	end

	always_ff @(posedge clk) begin
		sq_q       <= 20'(radius_q) * 20'(radius_q);
		wsum_q     <= wsum_c;
		falloff_q  <= (fq == '0) ? FALLOFF_W'(1) : fq;
		seedq_q    <= sprod[SEED_SHIFT +: 10];
		wsum2_q    <= wsum_q;
		seed_mod_q <= smod_c[6:0];
	end

	assign cfg = '{cx: cx_q, cy: cy_q, fo: fo_q, ab: ab_q, seed: seed_q,
		falloff: falloff_q, seed_mod: seed_mod_q, busy: (busy_q != 2'd0)};

	a_write_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr |=> busy_q == 2'd3)
		else $error("config write did not hold off pixel requests");

	a_falloff_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == 2'd0 |-> falloff_q != '0)
		else $error("falloff is zero while pixels are accepted");

endmodule

FILE: sv/wpg_div.sv
// Weather pixel generator intensity divider: 255 minus squared distance over
// falloff, clamped at zero; three pipelined stages of restoring division. Depends on wpg_pkg.
module wpg_div (
	input  logic                          clk,
	input  wpg_pkg::div_en_t              en,
	input  logic [20:0]                   dist2,
	input  logic [wpg_pkg::FALLOFF_W-1:0] falloff,
	output logic [7:0]                    intensity
);
	import wpg_pkg::*;

	logic [20:0] rem_s3, rem_s4;
	logic [7:0]  q_s3, q_s4, q_s5;
	logic        ovf_s3, ovf_s4, ovf_s5;

	logic [20:0] rem_a, rem_b, rem_c;
	logic [7:0]  q_a, q_b, q_c;
	logic        ovf_c;

	// quotient >= 256 drives intensity to zero
	always_comb begin
		ovf_c = dist2 >= {falloff, 8'b0};
		rem_a = dist2;
		q_a   = '0;
		for (int k = 7; k >= 6; k--) begin
			if (rem_a >= (21'(falloff) << k)) begin
				rem_a  = rem_a - (21'(falloff) << k);
				q_a[k] = 1'b1;
			end
		end
	end

	always_comb begin
		rem_b = rem_s3;
		q_b   = q_s3;
		for (int k = 5; k >= 3; k--) begin
			if (rem_b >= (21'(falloff) << k)) begin
				rem_b  = rem_b - (21'(falloff) << k);
				q_b[k] = 1'b1;
			end
		end
	end

	always_comb begin
		rem_c = rem_s4;
		q_c   = q_s4;
		for (int k = 2; k >= 0; k--) begin
			if (rem_c >= (21'(falloff) << k)) begin
				rem_c  = rem_c - (21'(falloff) << k);
				q_c[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			rem_s3 <= rem_a;
			q_s3   <= q_a;
			ovf_s3 <= ovf_c;
		end
		if (en.s4) begin
			rem_s4 <= rem_b;
			q_s4   <= q_b;
			ovf_s4 <= ovf_s3;
		end
		if (en.s5) begin
			q_s5   <= q_c;
			ovf_s5 <= ovf_s4;
		end
	end

	assign intensity = ovf_s5 ? 8'd0 : 8'd255 - q_s5;

endmodule

FILE: tb/procedural_weather_pixel_generator_tb.sv
// Testbench for procedural_weather_pixel_generator: drives pixel requests and
// register writes, predicts each BGR pixel and checks it in order of request.
// Depends on wpg_pkg (register index enum) and the generator top level.
module procedural_weather_pixel_generator_tb;
	import wpg_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 100;
	localparam int RANDOM_PHASES = 16;
	// indexes past the register list; writes to them must have no effect
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [9:0]  pixel_x;
	logic [9:0]  pixel_y;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  blue;
	logic [7:0]  green;
	logic [7:0]  red;

	// register shadow
	logic [9:0]  ctr_x;
	logic [9:0]  ctr_y;
	logic [9:0]  radius;
	logic [7:0]  front_ofs;
	logic [9:0]  alt_ofs;
	logic [31:0] seed;

	rgb_t pending_rgb[$];
	int   failures;
	int   cycles;
	bit   no_idle;
	int   ready_hold;

	procedural_weather_pixel_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.blue      (blue),
		.green     (green),
		.red       (red)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int tri_wave_of(input int phase, input int period, input int peak);
		int d;
		d = phase % period - peak;
		if (d < 0)
			d = -d;
		return (peak - d < 0) ? 0 : peak - d;
	endfunction

	function automatic logic [7:0] clamp_byte(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	function automatic rgb_t weather_pixel(input logic [9:0] px, input logic [9:0] py);
		int x, y, r, falloff, dx, dy, dist2, heat, front, stripe, turb;
		int b, g, rd;
		longint total;
		rgb_t c;
		x = int'(px);
		y = int'(py);
		r = int'(radius);
		falloff = (r * r) / 255;
		if (falloff < 1)
			falloff = 1;
		dx = x - int'(ctr_x);
		dy = y - int'(ctr_y);
		dist2 = dx * dx + dy * dy;
		heat = 255 - dist2 / falloff;
		if (heat < 0)
			heat = 0;
		front = tri_wave_of(x + y + int'(front_ofs), 240, 120);
		stripe = tri_wave_of(y * 2 + int'(alt_ofs), 180, 90);
		turb = tri_wave_of((x ^ y) + int'(seed[7:0]), 150, 75);
		b = 85 + (x * 70) / 1024 + int'(seed[20:16]) + heat / 2 + front / 5;
		g = 55 + (y * 65) / 1024 + int'(seed[12:8]) + heat / 4 + stripe / 3;
		rd = 20 + ((x + y) * 30) / 2048 + int'(seed[4:0]) + heat / 7 + front / 3 + turb / 4;
		total = longint'(x) + longint'(y) + longint'($signed(seed));
		if (heat > 205 && total % 97 == 0) begin
			rd = 250;
			g = 245;
			b = 220;
		end
		c.blue = clamp_byte(b);
		c.green = clamp_byte(g);
		c.red = clamp_byte(rd);
		return c;
	endfunction

	// row near the storm center that puts x + y + seed on a multiple of 97
	function automatic logic [9:0] speckle_row(input logic [9:0] x);
		longint s;
		int rem, y;
		s = longint'(x) + longint'(ctr_y) + longint'($signed(seed));
		rem = int'(s % 97);
		if (rem < 0)
			rem += 97;
		y = int'(ctr_y) - rem;
		if (y < 0)
			y += 97;
		return y[9:0];
	endfunction

	function automatic logic [9:0] near_point(input logic [9:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 40)) - 20;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v[9:0];
	endfunction

	function automatic int draw_wait();
		return no_idle ? 0 : int'($urandom_range(0, 16));
	endfunction

	// result checker and receiver-side stalls
	always @(posedge clk) begin : check_results
		rgb_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rgb.size() == 0) begin
				$error("result with no request outstanding: b=%0d g=%0d r=%0d",
					blue, green, red);
				failures++;
			end else begin
				want = pending_rgb.pop_front();
				if (blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, blue);
					failures++;
				end
				if (green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, green);
					failures++;
				end
				if (red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, red);
					failures++;
				end
			end
			ready_hold = draw_wait();
			out_ready <= (ready_hold == 0);
		end else if (!out_ready) begin
			if (ready_hold > 0)
				ready_hold--;
			if (ready_hold == 0)
				out_ready <= 1'b1;
		end
	end

	// leaves in_valid high after the request is taken; the next call decides
	task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
		int gap;
		gap = draw_wait();
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (!in_ready);
		pending_rgb.push_back(weather_pixel(x, y));
	endtask

	task automatic settle_pipeline();
		in_valid <= 1'b0;
		while (pending_rgb.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CENTER_X: ctr_x = data[9:0];
			REG_CENTER_Y: ctr_y = data[9:0];
			REG_RADIUS:   radius = data[9:0];
			REG_FRONT:    front_ofs = data[7:0];
			REG_ALTITUDE: alt_ofs = data[9:0];
			REG_SEED:     seed = data;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] cx, input logic [31:0] cy,
		input logic [31:0] rad, input logic [31:0] fo, input logic [31:0] ab,
		input logic [31:0] sd);
		settle_pipeline();
		reg_write(REG_CENTER_X, cx);
		reg_write(REG_CENTER_Y, cy);
		reg_write(REG_RADIUS, rad);
		reg_write(REG_FRONT, fo);
		reg_write(REG_ALTITUDE, ab);
		reg_write(REG_SEED, sd);
	endtask

	// reset values; the origin hits the speckle, and pixels summing to 97 hit it only near the origin
	task automatic test_reset_defaults();
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd97, 10'd0);
		send_pixel(10'd50, 10'd47);
		send_pixel(10'd60, 10'd37);
		send_pixel(10'd61, 10'd36);
	endtask

	// zero radius gives falloff 1; front offset past 239 wraps the band
	task automatic test_zero_radius_wrap();
		set_config(32'd512, 32'd512, 32'd0, 32'd255, 32'd1023, 32'h0000_1F1F);
		send_pixel(10'd512, 10'd512);
		send_pixel(10'd511, 10'd513);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
	endtask

	task automatic test_negative_seed();
		set_config(32'd100, 32'd191, 32'd1023, 32'd17, 32'd0, 32'hFFFF_FEDD);
		send_pixel(10'd100, 10'd191);
		send_pixel(10'd101, 10'd191);
		set_config(32'd700, 32'd700, 32'd1023, 32'd200, 32'd500, 32'h8000_0000);
		send_pixel(10'd700, speckle_row(10'd700));
		set_config(32'd300, 32'd300, 32'd900, 32'd0, 32'd90, 32'hFFFF_FFFF);
		send_pixel(10'd300, speckle_row(10'd300));
	endtask

	task automatic test_spare_index();
		settle_pipeline();
		reg_write(REG_SPARE_A, 32'hFFFF_FFFF);
		reg_write(REG_SPARE_B, 32'h1234_5678);
		send_pixel(10'd300, speckle_row(10'd300));
		send_pixel(10'd299, 10'd301);
	endtask

	// top seed tint bits plus full intensity push blue past 255
	task automatic test_saturation();
		set_config(32'd1023, 32'd0, 32'd1023, 32'd0, 32'd180, 32'h001F_1F1F);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd1000, 10'd20);
	endtask

	task automatic test_random_phases();
		logic [9:0] x, y;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0)
				set_config(32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0);
			else if (ph == 1)
				set_config(32'd1023, 32'd1023, 32'd1023, 32'd255, 32'd1023, 32'hFFFF_FFFF);
			else
				set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom());
			if ($urandom_range(0, 3) == 0)
				reg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 25 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 5))
					0, 1: begin
						x = 10'($urandom());
						y = 10'($urandom());
					end
					2, 3: begin
						x = near_point(ctr_x);
						y = near_point(ctr_y);
					end
					4: begin
						x = near_point(ctr_x);
						y = speckle_row(x);
					end
					default: begin
						x = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
						y = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
					end
				endcase
				send_pixel(x, y);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		out_ready = 1'b1;
		ready_hold = 0;
		failures = 0;
		cycles = 0;
		no_idle = 1'b0;
		ctr_x = '0;
		ctr_y = '0;
		radius = 10'd160;
		front_ofs = '0;
		alt_ofs = 10'd180;
		seed = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_zero_radius_wrap();
		test_negative_seed();
		test_spare_index();
		test_saturation();
		test_random_phases();

		settle_pipeline();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
